@@ sv/lz77_pkg.sv @@
// shared constants and types of the lz77 symbol decompressor
package lz77_pkg;

  // history window, a power of two so that a slot is the low bits of a position
  localparam int WindowSize     = 32768;
  localparam int HistAddrW      = $clog2(WindowSize);
  localparam int MaxMatch       = 258;
  localparam int BytesPerResult = 8;

  localparam int CmdW    = 2;
  localparam int LitW    = 8;
  localparam int LenW    = 9;
  localparam int DistW   = 16;
  localparam int PosW    = 24;
  localparam int DataW   = 64;
  localparam int CountW  = 4;
  localparam int StatusW = 2;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [CmdW-1:0] CmdLiteral = 2'd0;
  localparam logic [CmdW-1:0] CmdMatch   = 2'd1;

  // register index taken from paddr[2]
  localparam logic RegCapacity = 1'b0;

  typedef enum logic [StatusW-1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StBad  = 2'd2
  } status_e;

endpackage

@@ sv/lz77_ram.sv @@
// generic simple dual-port ram with one write port and a registered read port
module lz77_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lz77_symbol_decompressor_unit.sv @@
// top level of the lz77 symbol decompressor: symbol decode, copy engine and output register
//
// Input channel (in_valid_i / in_stall_o) takes one symbol per request: a literal, a match
// of copy_length_i bytes from match_distance back, or an invalid code. stream_start_i clears
// the write position and the error latch before the symbol is handled.
// Output channel (out_valid_o / out_stall_i) carries results of up to eight bytes each;
// last_of_symbol_o marks the final result of a symbol, bytes_total_o the running count.
// A literal, an empty match or an error gives a single result, without the copy engine.
// A match of L bytes is copied byte by byte: the history memory has one read port and each
// copied byte needs its own read, so the copy runs one byte per cycle while the output register
// is free; a source byte written in the cycle before is forwarded around the memory.
// Results leave through an output register; a new symbol is taken no earlier than the cycle
// in which the last result of the previous one leaves. While the receiver stalls with a
// result pending, the copy engine and the input side hold.
// Reset clears the write position, the error latch and the output register, and sets
// the capacity limit to its maximum. History needs no clearing: only bytes of the current
// stream are ever read.
// The capacity register lies at APB address 0; pready is always high.
module lz77_symbol_decompressor_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input symbols
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lz77_pkg::CmdW-1:0]         command_i,
  input  logic [lz77_pkg::LitW-1:0]         literal_byte_i,
  input  logic [lz77_pkg::LenW-1:0]         copy_length_i,
  input  logic [lz77_pkg::DistW-1:0]        match_distance_i,
  input  logic                              stream_start_i,
  // output results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lz77_pkg::DataW-1:0]        data_bytes_o,
  output logic [lz77_pkg::CountW-1:0]       byte_count_o,
  output logic                              last_of_symbol_o,
  output logic [lz77_pkg::StatusW-1:0]      status_o,
  output logic [lz77_pkg::PosW-1:0]         bytes_total_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lz77_pkg::ApbAddrW-1:0]     paddr,
  input  logic [lz77_pkg::ApbDataW-1:0]     pwdata,
  output logic [lz77_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  localparam int AW = lz77_pkg::HistAddrW;

  typedef enum logic {
    SIdle,
    SCopy
  } state_e;

  state_e                            state_q, state_d;
  logic [lz77_pkg::PosW-1:0]         pos_q, pos_d;
  logic                              err_q, err_d;
  lz77_pkg::status_e                 lst_q, lst_d;
  logic [lz77_pkg::PosW-1:0]         cap_q, cap_d;

  logic [lz77_pkg::LenW-1:0]         rd_left_q, rd_left_d;
  logic [lz77_pkg::LenW-1:0]         wr_left_q, wr_left_d;
  logic [AW-1:0]                     src_q, src_d;
  logic                              fwd_q, fwd_d;
  logic [7:0]                        fwd_byte_q, fwd_byte_d;
  logic [lz77_pkg::DataW-1:0]        acc_q, acc_d;
  logic [lz77_pkg::CountW-1:0]       fill_q, fill_d;

  logic                              out_valid_q, out_valid_d;
  logic [lz77_pkg::DataW-1:0]        out_data_q, out_data_d;
  logic [lz77_pkg::CountW-1:0]       out_count_q, out_count_d;
  logic                              out_last_q, out_last_d;
  lz77_pkg::status_e                 out_status_q, out_status_d;
  logic [lz77_pkg::PosW-1:0]         out_total_q, out_total_d;

  logic                              ram_we, ram_re;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  logic [7:0]                        ram_wdata, ram_rdata;

  logic                              out_free, accept, advance, emit;
  logic [lz77_pkg::PosW-1:0]         pos_eff;
  logic                              err_eff;
  lz77_pkg::status_e                 lst_eff;
  logic                              cap_lit, cap_match, len_over, dist_bad;
  logic [lz77_pkg::PosW-1:0]         src_full;
  logic [7:0]                        copy_byte;
  logic [lz77_pkg::DataW-1:0]        acc_new;
  logic [lz77_pkg::CountW-1:0]       fill_inc;
  logic                              cfg_we;

  lz77_ram #(
    .Width (8),
    .Depth (lz77_pkg::WindowSize)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == SIdle) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign advance    = (state_q == SCopy) && out_free;

  // a new stream clears position and latch before the symbol is looked at
  assign pos_eff = stream_start_i ? '0 : pos_q;
  assign err_eff = stream_start_i ? 1'b0 : err_q;
  assign lst_eff = stream_start_i ? lz77_pkg::StOk : lst_q;

  assign len_over  = copy_length_i > lz77_pkg::LenW'(lz77_pkg::MaxMatch);
  assign cap_lit   = pos_eff >= cap_q;
  assign cap_match = ({1'b0, pos_eff} + (lz77_pkg::PosW+1)'(copy_length_i))
                     > {1'b0, cap_q};
  assign dist_bad  = (match_distance_i == '0)
                  || (lz77_pkg::PosW'(match_distance_i) > pos_eff)
                  || ((lz77_pkg::PosW+1)'(match_distance_i)
                      > (lz77_pkg::PosW+1)'(lz77_pkg::WindowSize));
  assign src_full  = pos_eff - lz77_pkg::PosW'(match_distance_i);

  assign copy_byte = fwd_q ? fwd_byte_q : ram_rdata;
  assign fill_inc  = fill_q + 1'b1;
  assign emit      = (fill_inc == lz77_pkg::CountW'(lz77_pkg::BytesPerResult))
                  || (wr_left_q == lz77_pkg::LenW'(1));

  always_comb begin
    acc_new = acc_q;
    for (int j = 0; j < lz77_pkg::BytesPerResult; j++) begin
      if (fill_q == lz77_pkg::CountW'(j)) begin
        acc_new[8*j +: 8] = copy_byte;
      end
    end
  end

  assign cfg_we = psel && penable && pwrite && (paddr[2] == lz77_pkg::RegCapacity);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    err_d        = err_q;
    lst_d        = lst_q;
    cap_d        = cfg_we ? pwdata[lz77_pkg::PosW-1:0] : cap_q;
    rd_left_d    = rd_left_q;
    wr_left_d    = wr_left_q;
    src_d        = src_q;
    fwd_d        = fwd_q;
    fwd_byte_d   = fwd_byte_q;
    acc_d        = acc_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    out_total_d  = out_total_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q[AW-1:0];
    ram_wdata    = copy_byte;
    ram_re       = 1'b0;
    ram_raddr    = src_q + 1'b1;

    if (accept) begin
      pos_d        = pos_eff;
      err_d        = err_eff;
      lst_d        = lst_eff;
      out_valid_d  = 1'b1;
      out_data_d   = '0;
      out_count_d  = '0;
      out_last_d   = 1'b1;
      out_status_d = lz77_pkg::StOk;
      out_total_d  = pos_eff;
      if (err_eff) begin
        out_status_d = lst_eff;
      end else begin
        case (command_i)
          lz77_pkg::CmdLiteral: begin
            if (cap_lit) begin
              err_d        = 1'b1;
              lst_d        = lz77_pkg::StFull;
              out_status_d = lz77_pkg::StFull;
            end else begin
              ram_we      = 1'b1;
              ram_waddr   = pos_eff[AW-1:0];
              ram_wdata   = literal_byte_i;
              pos_d       = pos_eff + 1'b1;
              out_data_d  = lz77_pkg::DataW'(literal_byte_i);
              out_count_d = lz77_pkg::CountW'(1);
              out_total_d = pos_eff + 1'b1;
            end
          end
          lz77_pkg::CmdMatch: begin
            if (len_over) begin
              err_d        = 1'b1;
              lst_d        = lz77_pkg::StBad;
              out_status_d = lz77_pkg::StBad;
            end else if (cap_match) begin
              err_d        = 1'b1;
              lst_d        = lz77_pkg::StFull;
              out_status_d = lz77_pkg::StFull;
            end else if (dist_bad) begin
              err_d        = 1'b1;
              lst_d        = lz77_pkg::StBad;
              out_status_d = lz77_pkg::StBad;
            end else if (copy_length_i != '0) begin
              // first source read goes out now, the result comes from the copy engine
              out_valid_d = 1'b0;
              ram_re      = 1'b1;
              ram_raddr   = src_full[AW-1:0];
              src_d       = src_full[AW-1:0];
              fwd_d       = 1'b0;
              rd_left_d   = copy_length_i - 1'b1;
              wr_left_d   = copy_length_i;
              acc_d       = '0;
              fill_d      = '0;
              state_d     = SCopy;
            end
          end
          default: begin
            err_d        = 1'b1;
            lst_d        = lz77_pkg::StBad;
            out_status_d = lz77_pkg::StBad;
          end
        endcase
      end
    end

    if (advance) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q[AW-1:0];
      ram_wdata = copy_byte;
      pos_d     = pos_q + 1'b1;
      wr_left_d = wr_left_q - 1'b1;
      if (rd_left_q != '0) begin
        ram_re     = 1'b1;
        src_d      = src_q + 1'b1;
        rd_left_d  = rd_left_q - 1'b1;
        // distance one: the source is the byte being written this cycle
        fwd_d      = (ram_raddr == ram_waddr);
        fwd_byte_d = copy_byte;
      end
      if (emit) begin
        out_valid_d  = 1'b1;
        out_data_d   = acc_new;
        out_count_d  = fill_inc;
        out_last_d   = (wr_left_q == lz77_pkg::LenW'(1));
        out_status_d = lz77_pkg::StOk;
        out_total_d  = pos_q + 1'b1;
        acc_d        = '0;
        fill_d       = '0;
      end else begin
        acc_d  = acc_new;
        fill_d = fill_inc;
      end
      if (wr_left_q == lz77_pkg::LenW'(1)) begin
        state_d = SIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      pos_q        <= '0;
      err_q        <= 1'b0;
      lst_q        <= lz77_pkg::StOk;
      cap_q        <= '1;
      rd_left_q    <= '0;
      wr_left_q    <= '0;
      src_q        <= '0;
      fwd_q        <= 1'b0;
      fwd_byte_q   <= '0;
      acc_q        <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_count_q  <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= lz77_pkg::StOk;
      out_total_q  <= '0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      err_q        <= err_d;
      lst_q        <= lst_d;
      cap_q        <= cap_d;
      rd_left_q    <= rd_left_d;
      wr_left_q    <= wr_left_d;
      src_q        <= src_d;
      fwd_q        <= fwd_d;
      fwd_byte_q   <= fwd_byte_d;
      acc_q        <= acc_d;
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_total_q  <= out_total_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_bytes_o     = out_data_q;
  assign byte_count_o     = out_count_q;
  assign last_of_symbol_o = out_last_q;
  assign status_o         = out_status_q;
  assign bytes_total_o    = out_total_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lz77_pkg::RegCapacity)
                ? lz77_pkg::ApbDataW'(cap_q) : '0;

endmodule

@@ tb/sv/lz77_tb_pkg.sv @@
// request and result types plus the scoreboard of the lz77 symbol decompressor testbench
package lz77_tb_pkg;
  import lz77_pkg::*;

  localparam logic [CmdW-1:0] CmdBadLow   = 2'd2;
  localparam logic [CmdW-1:0] CmdBadHigh  = 2'd3;
  localparam logic [PosW-1:0] CapacityMax = '1;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [LitW-1:0]  literal;
    logic [LenW-1:0]  length;
    logic [DistW-1:0] distance;
    logic             start;
  } symbol_t;

  typedef struct packed {
    logic [DataW-1:0]   data;
    logic [CountW-1:0]  count;
    logic               last;
    logic [StatusW-1:0] status;
    logic [PosW-1:0]    total;
  } chunk_t;

  class lz77_stream_checker;
    logic [LitW-1:0] history [WindowSize];
    int unsigned     wr_pos;
    bit              err_latched;
    status_e         err_code;
    int unsigned     capacity;
    chunk_t          expected_chunks[$];
    int unsigned     mismatches;
    int unsigned     symbols;
    int unsigned     chunks;
    int unsigned     longest;
    int unsigned     status_seen[4];

    function new();
      wr_pos      = 0;
      err_latched = 1'b0;
      err_code    = StOk;
      capacity    = 32'(CapacityMax);
      mismatches  = 0;
      symbols     = 0;
      chunks      = 0;
      longest     = 0;
      status_seen = '{default: 0};
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("%0t MISMATCH: %s", $time, msg);
    endtask

    function int pending();
      return expected_chunks.size();
    endfunction

    function void queue_chunk(logic [DataW-1:0] data, int unsigned count, bit last,
                              status_e st);
      chunk_t c;
      c.data   = data;
      c.count  = count[CountW-1:0];
      c.last   = last;
      c.status = st;
      c.total  = wr_pos[PosW-1:0];
      expected_chunks.push_back(c);
    endfunction

    function void flag_error(status_e st);
      err_latched = 1'b1;
      err_code    = st;
      queue_chunk('0, 0, 1'b1, st);
    endfunction

    // works out every result an accepted request causes and advances the stream
    function void note_symbol(symbol_t s);
      int unsigned len;
      int unsigned back;
      int unsigned fill;
      int unsigned i;
      logic [DataW-1:0] data;
      logic [LitW-1:0]  b;
      len  = 32'(s.length);
      back = 32'(s.distance);
      fill = 0;
      data = '0;
      symbols++;
      if (s.start) begin
        wr_pos      = 0;
        err_latched = 1'b0;
        err_code    = StOk;
      end
      if (err_latched) begin
        queue_chunk('0, 0, 1'b1, err_code);
        return;
      end
      if (s.command == CmdLiteral) begin
        if (wr_pos >= capacity) begin
          flag_error(StFull);
        end else begin
          history[wr_pos % WindowSize] = s.literal;
          wr_pos++;
          queue_chunk(DataW'(s.literal), 1, 1'b1, StOk);
        end
      end else if (s.command != CmdMatch || len > MaxMatch) begin
        flag_error(StBad);
      end else if (wr_pos + len > capacity) begin
        flag_error(StFull);
      end else if (back == 0 || back > wr_pos || back > WindowSize) begin
        flag_error(StBad);
      end else if (len == 0) begin
        queue_chunk('0, 0, 1'b1, StOk);
      end else begin
        // byte by byte, so an overlapping copy reads what it has just written
        for (i = 0; i < len; i++) begin
          b = history[(wr_pos - back) % WindowSize];
          history[wr_pos % WindowSize] = b;
          wr_pos++;
          data[8*fill +: 8] = b;
          fill++;
          if (fill == BytesPerResult || i + 1 == len) begin
            queue_chunk(data, fill, i + 1 == len, StOk);
            data = '0;
            fill = 0;
          end
        end
      end
      if (wr_pos > longest) longest = wr_pos;
    endfunction

    task check_chunk(chunk_t got);
      chunk_t want;
      if (expected_chunks.size() == 0) begin
        report($sformatf("result with none pending: data %h count %0d status %0d",
                         got.data, got.count, got.status));
        return;
      end
      want = expected_chunks.pop_front();
      chunks++;
      status_seen[want.status]++;
      if (got.data !== want.data)
        report($sformatf("result %0d data_bytes %h, want %h", chunks, got.data, want.data));
      if (got.count !== want.count)
        report($sformatf("result %0d byte_count %0d, want %0d", chunks, got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("result %0d last_of_symbol %b, want %b", chunks, got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, want %0d", chunks, got.status, want.status));
      if (got.total !== want.total)
        report($sformatf("result %0d bytes_total %0d, want %0d", chunks, got.total, want.total));
    endtask
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
// top of the lz77 symbol decompressor testbench: clock, reset, drivers and test sequence
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lz77_pkg::*;
  import lz77_tb_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 300;
  localparam logic [ApbAddrW-1:0] CapacityAddr = {RegCapacity, 2'b00};

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  logic [CmdW-1:0]     command;
  logic [LitW-1:0]     literal_byte;
  logic [LenW-1:0]     copy_length;
  logic [DistW-1:0]    match_distance;
  logic                stream_start;
  logic                out_valid;
  logic                out_stall;
  logic [DataW-1:0]    data_bytes;
  logic [CountW-1:0]   byte_count;
  logic                last_of_symbol;
  logic [StatusW-1:0]  status;
  logic [PosW-1:0]     bytes_total;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  lz77_stream_checker sb;
  bit                 calm;
  int unsigned        cycle_count;

  lz77_symbol_decompressor_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .literal_byte_i   (literal_byte),
    .copy_length_i    (copy_length),
    .match_distance_i (match_distance),
    .stream_start_i   (stream_start),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .data_bytes_o     (data_bytes),
    .byte_count_o     (byte_count),
    .last_of_symbol_o (last_of_symbol),
    .status_o         (status),
    .bytes_total_o    (bytes_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count, sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall before each result, none in calm stretches
  initial begin : result_sink
    int unsigned hold;
    chunk_t      got;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
      got.data   = data_bytes;
      got.count  = byte_count;
      got.last   = last_of_symbol;
      got.status = status;
      got.total  = bytes_total;
      sb.check_chunk(got);
    end
  end

  function automatic symbol_t sym(logic [CmdW-1:0] cmd, logic [LitW-1:0] lit,
                                  logic [LenW-1:0] len, logic [DistW-1:0] back, logic start);
    symbol_t s;
    s.command  = cmd;
    s.literal  = lit;
    s.length   = len;
    s.distance = back;
    s.start    = start;
    return s;
  endfunction

  // mostly well-formed requests against the predicted stream, some noise
  function automatic symbol_t random_symbol(int unsigned noise_pct);
    symbol_t     s;
    int unsigned pos;
    int unsigned room;
    int unsigned pick;
    s.command  = CmdLiteral;
    s.literal  = LitW'($urandom);
    s.length   = LenW'($urandom);
    s.distance = DistW'($urandom);
    s.start    = ($urandom_range(0, 24) == 0) || (sb.err_latched && $urandom_range(0, 3) != 0);
    pos  = s.start ? 0 : sb.wr_pos;
    room = (pos < WindowSize) ? pos : WindowSize;
    if ($urandom_range(0, 99) < noise_pct) begin
      case ($urandom_range(0, 3))
        0: s.command = $urandom_range(0, 1) ? CmdBadLow : CmdBadHigh;
        1: begin
          s.command = CmdMatch;
          s.length  = LenW'($urandom_range(MaxMatch + 1, 511));
        end
        2: begin
          s.command  = CmdMatch;
          s.distance = '0;
        end
        default: begin
          s.command  = CmdMatch;
          s.distance = DistW'($urandom_range(room + 1, 65535));
        end
      endcase
    end else if (room != 0 && $urandom_range(0, 9) >= 4) begin
      s.command  = CmdMatch;
      pick       = $urandom_range(0, 19);
      s.length   = LenW'((pick < 14) ? $urandom_range(0, 16) :
                         (pick < 19) ? $urandom_range(17, 64) : $urandom_range(65, MaxMatch));
      s.distance = DistW'($urandom_range(1, room));
    end
    return s;
  endfunction

  task automatic send_symbol(symbol_t s);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid       <= 1'b1;
    command        <= s.command;
    literal_byte   <= s.literal;
    copy_length    <= s.length;
    match_distance <= s.distance;
    stream_start   <= s.start;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    sb.note_symbol(s);
  endtask

  // stop requesting and wait for every pending result
  task automatic drain(int unsigned extra);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic apb_access(bit is_write, logic [ApbAddrW-1:0] addr,
                            logic [ApbDataW-1:0] wdata, output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_capacity();
    logic [ApbDataW-1:0] rd;
    apb_access(1'b0, CapacityAddr, '0, rd);
    if (rd[PosW-1:0] !== sb.capacity[PosW-1:0])
      sb.report($sformatf("capacity register reads %0d, want %0d", rd[PosW-1:0],
                          sb.capacity));
  endtask

  task automatic set_capacity(logic [PosW-1:0] value);
    logic [ApbDataW-1:0] rd;
    drain(4);
    apb_access(1'b1, CapacityAddr, ApbDataW'(value), rd);
    sb.capacity = 32'(value);
    check_capacity();
  endtask

  initial begin : test_sequence
    int unsigned     n;
    int unsigned     phase;
    int unsigned     room;
    logic [PosW-1:0] caps [4];
    sb             = new();
    calm           = 1'b0;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    command        = CmdLiteral;
    literal_byte   = '0;
    copy_length    = '0;
    match_distance = '0;
    stream_start   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_capacity();

    send_symbol(sym(CmdLiteral, 8'h00, 0, 0, 1'b1));
    // unused fields all ones must be ignored
    send_symbol(sym(CmdLiteral, 8'hff, 9'h1ff, 16'hffff, 1'b0));
    send_symbol(sym(CmdMatch, 8'h3c, 0, 1, 1'b0));
    // overlapping copy repeats the last byte
    send_symbol(sym(CmdMatch, 8'h00, 5, 1, 1'b0));
    send_symbol(sym(CmdMatch, 8'h00, LenW'(MaxMatch), 2, 1'b0));
    send_symbol(sym(CmdMatch, 8'h00, LenW'(BytesPerResult), 7, 1'b0));
    send_symbol(sym(CmdMatch, 8'h00, 9, 3, 1'b0));
    send_symbol(sym(CmdMatch, 8'h00, 4, 0, 1'b0));
    // latched error swallows this one
    send_symbol(sym(CmdLiteral, 8'h11, 0, 0, 1'b0));
    send_symbol(sym(CmdLiteral, 8'ha5, 0, 0, 1'b1));
    send_symbol(sym(CmdMatch, 8'h00, 3, 2, 1'b0));
    send_symbol(sym(CmdBadLow, 8'h00, 0, 0, 1'b1));
    send_symbol(sym(CmdBadHigh, 8'hff, 9'h1ff, 16'hffff, 1'b1));
    send_symbol(sym(CmdLiteral, 8'h5a, 0, 0, 1'b1));
    send_symbol(sym(CmdMatch, 8'h00, LenW'(MaxMatch + 1), 1, 1'b0));
    // overlong length is caught ahead of the zero distance
    send_symbol(sym(CmdMatch, 8'h00, 9'h1ff, 0, 1'b1));
    send_symbol(sym(CmdMatch, 8'h00, 0, 0, 1'b1));

    set_capacity('0);
    send_symbol(sym(CmdLiteral, 8'h77, 0, 0, 1'b1));
    send_symbol(sym(CmdMatch, 8'h00, 0, 1, 1'b1));
    set_capacity(1);
    send_symbol(sym(CmdLiteral, 8'h77, 0, 0, 1'b1));
    send_symbol(sym(CmdMatch, 8'h00, 0, 1, 1'b0));
    // over capacity and bad distance at once: capacity wins
    send_symbol(sym(CmdMatch, 8'h00, 1, 5, 1'b0));

    caps[0] = CapacityMax;
    caps[1] = PosW'($urandom_range(30, 120));
    caps[2] = PosW'($urandom_range(200, 700));
    caps[3] = PosW'($urandom_range(0, CapacityMax));
    for (phase = 0; phase < 4; phase++) begin
      set_capacity(caps[phase]);
      for (n = 0; n < 4; n++) begin
        if (n % 16 == 0) calm = ($urandom_range(0, 3) == 0);
        if (phase == 1 && n == 2) drain(0);
        send_symbol(random_symbol(12));
      end
    end

    // one long stream so that the history wraps and the window limit is reached
    set_capacity(PosW'(WindowSize + 600));
    send_symbol(sym(CmdLiteral, LitW'($urandom), 0, 0, 1'b1));
    n = 0;
    while (sb.wr_pos <= WindowSize + 8) begin
      if (n % 16 == 0) calm = ($urandom_range(0, 1) == 0);
      n++;
      room = (sb.wr_pos < WindowSize) ? sb.wr_pos : WindowSize;
      send_symbol(sym(CmdMatch, LitW'($urandom), LenW'(MaxMatch),
                      DistW'($urandom_range(1, room)), 1'b0));
    end
    calm = 1'b0;
    send_symbol(sym(CmdMatch, 8'h00, 16, DistW'(WindowSize), 1'b0));
    send_symbol(sym(CmdMatch, 8'h00, 16, DistW'(WindowSize + 1), 1'b0));
    set_capacity(CapacityMax);
    send_symbol(sym(CmdLiteral, LitW'($urandom), 0, 0, 1'b1));

    drain(SettleCycles);
    $display("Checked %0d results from %0d requests; longest stream %0d bytes.",
             sb.chunks, sb.symbols, sb.longest);
    $display("Result status mix: %0d ok, %0d over capacity, %0d invalid data.",
             sb.status_seen[StOk], sb.status_seen[StFull], sb.status_seen[StBad]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
